/* design/rmq_pkg.sv */
// rotation matrix to quaternion: shared types and constants
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    // fixed field widths of the channels
    localparam int ELEM_W = 16;
    localparam int QOUT_W = 16;
    localparam int IDX_W  = 2;

    // number of quaternion components
    localparam int N_COMP = 4;

    // largest component codes
    typedef enum logic [IDX_W-1:0] {
        QIDX_W = 2'd0,
        QIDX_X = 2'd1,
        QIDX_Y = 2'd2,
        QIDX_Z = 2'd3
    } t_qidx;

endpackage

`default_nettype wire

/* design/rmq_if.sv */
// channel interfaces: matrix input and quaternion result, valid/ready
// depends on rmq_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface rmq_mat_if import rmq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
    logic signed [ELEM_W-1:0] m13;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
    logic signed [ELEM_W-1:0] m23;
    logic signed [ELEM_W-1:0] m31;
    logic signed [ELEM_W-1:0] m32;
    logic signed [ELEM_W-1:0] m33;

    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                  output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [QOUT_W-1:0] qw;
    logic signed [QOUT_W-1:0] qx;
    logic signed [QOUT_W-1:0] qy;
    logic signed [QOUT_W-1:0] qz;
    logic [IDX_W-1:0]         largest_index;

    modport source (output valid, qw, qx, qy, qz, largest_index, input ready);
    modport sink (input valid, qw, qx, qy, qz, largest_index, output ready);
endinterface

`default_nettype wire

/* design/rmq_sqrt_pipe.sv */
// pipelined integer square root, one result bit per register stage
// several lanes share valid, stall enable and a sideband word; uses rmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmq_sqrt_pipe import rmq_pkg::*; #(
    parameter int RW    = 32,
    parameter int LANES = 4,
    parameter int SBW   = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [LANES-1:0][RW-1:0]        i_rad,
    input  wire logic [SBW-1:0]                  i_sb,
    output logic                                 o_valid,
    output logic [LANES-1:0][RW/2-1:0]           o_root,
    output logic [SBW-1:0]                       o_sb
);

    localparam int QW = RW / 2;

    logic                          r_v   [QW];
    logic [LANES-1:0][RW-1:0]      r_x   [QW];
    logic [LANES-1:0][QW:0]        r_rem [QW];
    logic [LANES-1:0][QW-1:0]      r_q   [QW];
    logic [SBW-1:0]                r_sb  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic                     v_in;
        logic [LANES-1:0][RW-1:0] x_in;
        logic [LANES-1:0][QW:0]   rem_in;
        logic [LANES-1:0][QW-1:0] q_in;
        logic [SBW-1:0]           sb_in;
        logic [LANES-1:0][RW-1:0] n_x;
        logic [LANES-1:0][QW:0]   n_rem;
        logic [LANES-1:0][QW-1:0] n_q;

        // stage inputs: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign x_in   = i_rad;
            assign rem_in = '0;
            assign q_in   = '0;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign x_in   = r_x[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign sb_in  = r_sb[k-1];
        end

        // one trial subtract per lane, bring down two radicand bits
        always_comb begin
            logic [QW+1:0] cur;
            logic [QW+1:0] trial;
            logic          ge;
            for (int l = 0; l < LANES; l++) begin
                cur      = {rem_in[l][QW-1:0], x_in[l][RW-1:RW-2]};
                trial    = {q_in[l], 2'b01};
                ge       = (cur >= trial);
                n_rem[l] = ge ? (QW+1)'(cur - trial) : (QW+1)'(cur);
                n_q[l]   = {q_in[l][QW-2:0], ge};
                n_x[l]   = x_in[l] << 2;
            end
        end

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_root  = r_q[QW-1];
    assign o_sb    = r_sb[QW-1];

endmodule

`default_nettype wire

/* design/rmq_div_pipe.sv */
// pipelined restoring divider, one quotient bit per register stage
// lanes share one divisor, valid, stall enable and sideband; uses rmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module rmq_div_pipe import rmq_pkg::*; #(
    parameter int NW    = 31,
    parameter int DW    = 17,
    parameter int QB    = 15,
    parameter int LANES = 4,
    parameter int SBW   = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [LANES-1:0][NW-1:0]  i_num,
    input  wire logic [DW-1:0]             i_den,
    input  wire logic [SBW-1:0]            i_sb,
    output logic                           o_valid,
    output logic [LANES-1:0][QB-1:0]       o_quo,
    output logic [SBW-1:0]                 o_sb
);

    logic                      r_v   [QB];
    logic [LANES-1:0][QB-1:0]  r_x   [QB];
    logic [LANES-1:0][DW-1:0]  r_rem [QB];
    logic [LANES-1:0][QB-1:0]  r_q   [QB];
    logic [DW-1:0]             r_d   [QB];
    logic [SBW-1:0]            r_sb  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_st
        logic                     v_in;
        logic [LANES-1:0][QB-1:0] x_in;
        logic [LANES-1:0][DW-1:0] rem_in;
        logic [LANES-1:0][QB-1:0] q_in;
        logic [DW-1:0]            d_in;
        logic [SBW-1:0]           sb_in;
        logic [LANES-1:0][QB-1:0] n_x;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QB-1:0] n_q;

        // high numerator bits seed the remainder (always below the divisor)
        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    x_in[l]   = i_num[l][QB-1:0];
                    rem_in[l] = DW'(i_num[l][NW-1:QB]);
                end
            end
            assign v_in  = i_valid;
            assign q_in  = '0;
            assign d_in  = i_den;
            assign sb_in = i_sb;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign x_in   = r_x[k-1];
            assign rem_in = r_rem[k-1];
            assign q_in   = r_q[k-1];
            assign d_in   = r_d[k-1];
            assign sb_in  = r_sb[k-1];
        end

        // shift in one numerator bit, subtract divisor when it fits
        always_comb begin
            logic [DW:0] cur;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                cur      = {rem_in[l], x_in[l][QB-1]};
                ge       = (cur >= {1'b0, d_in});
                n_rem[l] = ge ? DW'(cur - {1'b0, d_in}) : DW'(cur);
                n_q[l]   = {q_in[l][QB-2:0], ge};
                n_x[l]   = x_in[l] << 1;
            end
        end

        // valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        // payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_rem[k] <= n_rem;
                r_q[k]   <= n_q;
                r_d[k]   <= d_in;
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_quo   = r_q[QB-1];
    assign o_sb    = r_sb[QB-1];

endmodule

`default_nettype wire

/* design/rotation_matrix_to_quaternion_top.sv */
// rotation matrix to unit quaternion, top level pipeline
// depends on rmq_pkg, rmq_if, rmq_sqrt_pipe and rmq_div_pipe
`timescale 1ns / 1ps
`default_nettype none

// Converts a 3x3 rotation matrix (signed fixed point, FRAC_BITS fraction bits)
// into a unit quaternion plus the index of its largest component. The block is
// a fully pipelined datapath: it takes one matrix per clock and delivers one
// quaternion per clock as long as the result side keeps ready high. The
// pipeline runs through two bit-per-stage square root pipelines (trace terms,
// then the norm) and the bit-per-stage divider that normalizes all four
// components. When the result is not taken, the whole pipeline holds; nothing
// is dropped or repeated.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);

    // derived widths
    localparam int TW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int TS  = TW + 1;
    localparam int RW0 = TW + FRAC_BITS;
    localparam int RW  = RW0 + (RW0 % 2);
    localparam int SW  = RW / 2;
    localparam int PW  = 2 * SW;
    localparam int SUW = 2 * SW + 2;
    localparam int DW  = SW + 1;
    localparam int NW  = SW + FRAC_BITS + 1;
    localparam int QB  = FRAC_BITS + 1;
    localparam int MW  = (QB > QOUT_W) ? QB : QOUT_W;
    localparam int SB2 = N_COMP * SW + IDX_W + N_COMP;
    localparam int SB3 = IDX_W + N_COMP + 1;

    localparam logic signed [TS-1:0] ONE_T = TS'(1) << FRAC_BITS;

    function automatic logic neg_diff(logic signed [ELEM_W-1:0] a,
                                      logic signed [ELEM_W-1:0] b);
        logic signed [ELEM_W:0] d;
        d = (ELEM_W+1)'(a) - (ELEM_W+1)'(b);
        return d[ELEM_W];
    endfunction

    function automatic logic neg_sum(logic signed [ELEM_W-1:0] a,
                                     logic signed [ELEM_W-1:0] b);
        logic signed [ELEM_W:0] d;
        d = (ELEM_W+1)'(a) + (ELEM_W+1)'(b);
        return d[ELEM_W];
    endfunction

    // global stall: everything moves when the output register can take data
    logic w_en;
    logic r_out_v;
    assign w_en        = !r_out_v || o_quat.ready;
    assign i_mat.ready = w_en;

    // stage a: trace terms and off-diagonal sign bits
    logic                          r_a_v;
    logic [N_COMP-1:0][TW-1:0]     r_a_t;
    logic [5:0]                    r_a_sg;
    logic [N_COMP-1:0][TW-1:0]     n_a_t;
    logic [5:0]                    n_a_sg;

    always_comb begin
        logic signed [TS-1:0] e11;
        logic signed [TS-1:0] e22;
        logic signed [TS-1:0] e33;
        logic signed [TS-1:0] t [N_COMP];
        e11  = TS'(i_mat.m11);
        e22  = TS'(i_mat.m22);
        e33  = TS'(i_mat.m33);
        t[0] =  e11 + e22 + e33 + ONE_T;
        t[1] =  e11 - e22 - e33 + ONE_T;
        t[2] = -e11 + e22 - e33 + ONE_T;
        t[3] = -e11 - e22 + e33 + ONE_T;
        for (int k = 0; k < N_COMP; k++) begin
            n_a_t[k] = t[k][TS-1] ? '0 : t[k][TW-1:0];
        end
        // bit order: d32_23, d13_31, d21_12, a21_12, a13_31, a32_23
        n_a_sg[0] = neg_diff(i_mat.m32, i_mat.m23);
        n_a_sg[1] = neg_diff(i_mat.m13, i_mat.m31);
        n_a_sg[2] = neg_diff(i_mat.m21, i_mat.m12);
        n_a_sg[3] = neg_sum(i_mat.m21, i_mat.m12);
        n_a_sg[4] = neg_sum(i_mat.m13, i_mat.m31);
        n_a_sg[5] = neg_sum(i_mat.m32, i_mat.m23);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_t  <= n_a_t;
            r_a_sg <= n_a_sg;
        end
    end

    // trace roots, four lanes
    logic [N_COMP-1:0][RW-1:0] w_rad1;
    logic                      w_s_v;
    logic [N_COMP-1:0][SW-1:0] w_s;
    logic [5:0]                w_s_sg;

    always_comb begin
        for (int k = 0; k < N_COMP; k++) begin
            w_rad1[k] = RW'({r_a_t[k], {FRAC_BITS{1'b0}}});
        end
    end

    rmq_sqrt_pipe #(.RW(RW), .LANES(N_COMP), .SBW(6)) u_root_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_v),
        .i_rad   (w_rad1),
        .i_sb    (r_a_sg),
        .o_valid (w_s_v),
        .o_root  (w_s),
        .o_sb    (w_s_sg)
    );

    // stage b: largest pick, sign resolve, squares
    logic                      r_b_v;
    logic [N_COMP-1:0][SW-1:0] r_b_s;
    logic [N_COMP-1:0][PW-1:0] r_b_p;
    logic [IDX_W-1:0]          r_b_big;
    logic [N_COMP-1:0]         r_b_neg;
    t_qidx                     n_b_big;
    logic [N_COMP-1:0]         n_b_neg;

    always_comb begin
        logic [SW-1:0] best;
        best    = w_s[0];
        n_b_big = QIDX_W;
        if (w_s[1] > best) begin
            best    = w_s[1];
            n_b_big = QIDX_X;
        end
        if (w_s[2] > best) begin
            best    = w_s[2];
            n_b_big = QIDX_Y;
        end
        if (w_s[3] > best) begin
            n_b_big = QIDX_Z;
        end
        n_b_neg = '0;
        case (n_b_big)
            QIDX_W: begin
                n_b_neg[1] = w_s_sg[0];
                n_b_neg[2] = w_s_sg[1];
                n_b_neg[3] = w_s_sg[2];
            end
            QIDX_X: begin
                n_b_neg[0] = w_s_sg[0];
                n_b_neg[2] = w_s_sg[3];
                n_b_neg[3] = w_s_sg[4];
            end
            QIDX_Y: begin
                n_b_neg[0] = w_s_sg[1];
                n_b_neg[1] = w_s_sg[3];
                n_b_neg[3] = w_s_sg[5];
            end
            default: begin
                n_b_neg[0] = w_s_sg[2];
                n_b_neg[1] = w_s_sg[4];
                n_b_neg[2] = w_s_sg[5];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_en) begin
            r_b_v <= w_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_s   <= w_s;
            r_b_big <= n_b_big;
            r_b_neg <= n_b_neg;
            for (int k = 0; k < N_COMP; k++) begin
                r_b_p[k] <= PW'(w_s[k]) * PW'(w_s[k]);
            end
        end
    end

    // stage c: sum of squares
    logic                      r_c_v;
    logic [SUW-1:0]            r_c_sum;
    logic [N_COMP-1:0][SW-1:0] r_c_s;
    logic [IDX_W-1:0]          r_c_big;
    logic [N_COMP-1:0]         r_c_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_sum <= SUW'(r_b_p[0]) + SUW'(r_b_p[1]) + SUW'(r_b_p[2]) + SUW'(r_b_p[3]);
            r_c_s   <= r_b_s;
            r_c_big <= r_b_big;
            r_c_neg <= r_b_neg;
        end
    end

    // norm root, single lane; roots and signs ride along
    logic [0:0][SUW-1:0] w_rad2;
    logic                w_n_v;
    logic [0:0][DW-1:0]  w_n;
    logic [SB2-1:0]      w_n_sb;

    assign w_rad2[0] = r_c_sum;

    rmq_sqrt_pipe #(.RW(SUW), .LANES(1), .SBW(SB2)) u_root_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_rad   (w_rad2),
        .i_sb    ({r_c_s, r_c_big, r_c_neg}),
        .o_valid (w_n_v),
        .o_root  (w_n),
        .o_sb    (w_n_sb)
    );

    // numerators: root shifted up plus half the norm, for round half up
    logic [N_COMP-1:0][SW-1:0] w_d_s;
    logic [IDX_W-1:0]          w_d_big;
    logic [N_COMP-1:0]         w_d_neg;
    logic [N_COMP-1:0][NW-1:0] w_num;
    logic                      w_d_zero;

    assign {w_d_s, w_d_big, w_d_neg} = w_n_sb;
    assign w_d_zero = (w_n[0] == '0);

    always_comb begin
        for (int k = 0; k < N_COMP; k++) begin
            w_num[k] = NW'({w_d_s[k], {FRAC_BITS{1'b0}}}) + NW'(w_n[0] >> 1);
        end
    end

    logic                      w_q_v;
    logic [N_COMP-1:0][QB-1:0] w_quo;
    logic [SB3-1:0]            w_q_sb;

    rmq_div_pipe #(.NW(NW), .DW(DW), .QB(QB), .LANES(N_COMP), .SBW(SB3)) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_n_v),
        .i_num   (w_num),
        .i_den   (w_n[0]),
        .i_sb    ({w_d_big, w_d_neg, w_d_zero}),
        .o_valid (w_q_v),
        .o_quo   (w_quo),
        .o_sb    (w_q_sb)
    );

    // output stage: zero on a zero norm, saturate, apply sign
    logic [IDX_W-1:0]                 w_o_big;
    logic [N_COMP-1:0]                w_o_neg;
    logic                             w_o_zero;
    logic [N_COMP-1:0][QOUT_W-1:0]    n_out_q;
    logic [N_COMP-1:0][QOUT_W-1:0]    r_out_q;
    logic [IDX_W-1:0]                 r_out_big;

    assign {w_o_big, w_o_neg, w_o_zero} = w_q_sb;

    always_comb begin
        logic [MW-1:0]     mag_w;
        logic [QOUT_W-1:0] mag;
        for (int k = 0; k < N_COMP; k++) begin
            mag_w = MW'(w_quo[k]);
            if (w_o_zero) begin
                mag_w = '0;
            end else if (mag_w > MW'(16'h7fff)) begin
                mag_w = MW'(16'h7fff);
            end
            mag        = mag_w[QOUT_W-1:0];
            n_out_q[k] = w_o_neg[k] ? (QOUT_W'(0) - mag) : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_q   <= n_out_q;
            r_out_big <= w_o_big;
        end
    end

    assign o_quat.valid         = r_out_v;
    assign o_quat.qw            = r_out_q[0];
    assign o_quat.qx            = r_out_q[1];
    assign o_quat.qy            = r_out_q[2];
    assign o_quat.qz            = r_out_q[3];
    assign o_quat.largest_index = r_out_big;

    // largest component never comes out negative
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> ((o_quat.largest_index == QIDX_W && !o_quat.qw[QOUT_W-1]) ||
                          (o_quat.largest_index == QIDX_X && !o_quat.qx[QOUT_W-1]) ||
                          (o_quat.largest_index == QIDX_Y && !o_quat.qy[QOUT_W-1]) ||
                          (o_quat.largest_index == QIDX_Z && !o_quat.qz[QOUT_W-1])))
        else $error("largest quaternion component is negative");

    // reset empties the pipeline
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_quat.valid)
        else $error("result valid right after reset");

    // a held result keeps its payload while the pipeline stalls
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_quat.valid && !o_quat.ready) |=> (o_quat.valid && $stable(r_out_q)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
